// ===== hdl/mbsra_pkg.sv =====
// Shared types and constants for the multi-bit state run allocator.
// Used by mbsra_unit, the top level and the testbench; depends on nothing.
package mbsra_pkg;

	localparam int CAPACITY       = 1024;
	localparam int BITS_PER_STATE = 2;
	localparam int STATE_LIMIT    = (BITS_PER_STATE >= 2) ? 4 : (1 << BITS_PER_STATE);

	// fixed item field widths
	localparam int CMD_W   = 2;
	localparam int ST_W    = 2;
	localparam int LEN_W   = 11;
	localparam int START_W = 10;
	localparam int STS_W   = 2;
	localparam int FOUND_W = 10;
	localparam int RD_W    = 2;
	localparam int PERM_W  = 16;

	localparam int IDX_W  = $clog2(CAPACITY);
	localparam int CAP_CW = $clog2(CAPACITY + 1);
	localparam int SUM_W  = (CAP_CW > LEN_W + 1) ? CAP_CW : LEN_W + 1;

	// APB register map
	localparam int ADDR_W = 3;
	localparam logic REG_ALLOWED_IDX = 1'b0;

	typedef enum logic [CMD_W-1:0] {
		CMD_FIND  = 2'd0,
		CMD_CHECK = 2'd1,
		CMD_READ  = 2'd2,
		CMD_SET   = 2'd3
	} cmd_t;

	typedef enum logic [STS_W-1:0] {
		STS_OK      = 2'd0,
		STS_FAIL    = 2'd1,
		STS_INVALID = 2'd2
	} sts_t;

	// request into the shared compare unit
	typedef struct packed {
		logic [BITS_PER_STATE-1:0] old_state;
		logic [ST_W-1:0]           target;
		logic [LEN_W-1:0]          run;
		logic [LEN_W-1:0]          rem;
		logic [LEN_W-1:0]          len;
		logic [IDX_W-1:0]          addr;
		logic [PERM_W-1:0]         allowed;
	} unit_req_t;

	// per-entry verdict from the shared compare unit
	typedef struct packed {
		logic             match;
		logic             permit;
		logic [LEN_W-1:0] run_next;
		logic             run_hit;
		logic             rem_last;
		logic             addr_end;
		logic [IDX_W-1:0] found;
	} unit_res_t;

endpackage

// ===== hdl/mbsra_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module mbsra_ram #(
	parameter int DEPTH = 1024,
	parameter int WIDTH = 2,
	parameter int AW    = 10
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== hdl/mbsra_unit.sv =====
// Shared per-entry compare unit: state match, transition permission,
// run counting and end-of-scan detection. Depends on mbsra_pkg.
module mbsra_unit import mbsra_pkg::*; (
	input  unit_req_t req,
	output unit_res_t res
);

	logic [3:0]       perm_idx;
	logic [SUM_W-1:0] start_sum;

	always_comb begin
		res.match    = (3'(req.old_state) == 3'(req.target));
		perm_idx     = {2'(req.old_state), req.target};
		res.permit   = req.allowed[perm_idx];
		res.run_next = res.match ? (req.run + LEN_W'(1)) : '0;
		res.run_hit  = res.match && (res.run_next == req.len);
		res.rem_last = (req.rem == LEN_W'(1));
		res.addr_end = (req.addr == IDX_W'(CAPACITY - 1));
		start_sum    = SUM_W'(req.addr) + SUM_W'(1) - SUM_W'(req.len);
		res.found    = start_sum[IDX_W-1:0];
	end

endmodule

// ===== hdl/multi_bit_state_run_allocator.sv =====
// Top level of the multi-bit state run allocator: sequencer, APB register,
// output register. Depends on mbsra_pkg, mbsra_ram and mbsra_unit.
//
// Usage:
//  - Command items enter on the s_ stream (s_tuser = command, s_tdata = state,
//    length, start index). One result item leaves on the m_ stream for each.
//  - APB register 0 (byte address 0) is allowed_transitions; bit old*4+new
//    permits a set to change an entry from old to new. Reset value 0xFFFF.
//  - After reset the state store is swept to zero, one entry a cycle:
//    with s_tready low. APB writes are taken during the sweep.
//  - One item at a time. The sequencer walks the store through the shared
//    compare unit, one entry per cycle, limited by the single RAM read port.
//    Read examines one entry; check and set walk run_length entries and stop
//    early on a mismatch or a refused entry; find walks from entry 0 and
//    stops at the first fit or at the end of the store; invalid arguments
//    skip the scan. s_tready returns in the same cycle that m_tvalid rises
//    with the result.
//  - Results sit in an output register. s_tready comes back as soon as the
//    result is parked there; a stalled m_tready only blocks the next item's
//    completion, which waits in the done state until the register frees.
module multi_bit_state_run_allocator import mbsra_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	// s_tdata: [1:0] state_value, [12:2] run_length, [22:13] start_index
	input  logic              s_tvalid,
	output logic              s_tready,
	input  logic [23:0]       s_tdata,
	// s_tuser: [1:0] command
	input  logic [CMD_W-1:0]  s_tuser,
	// m_tdata: [1:0] status, [11:2] found_index, [13:12] read_state
	output logic              m_tvalid,
	input  logic              m_tready,
	output logic [15:0]       m_tdata,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);

	typedef enum logic [3:0] {
		ST_CLEAR = 4'b0001,
		ST_IDLE  = 4'b0010,
		ST_SCAN  = 4'b0100,
		ST_DONE  = 4'b1000
	} fsm_t;

	fsm_t state_q;

	// input field unpack
	logic [ST_W-1:0]    in_st;
	logic [LEN_W-1:0]   in_len;
	logic [START_W-1:0] in_start;
	assign in_st    = s_tdata[1:0];
	assign in_len   = s_tdata[12:2];
	assign in_start = s_tdata[22:13];

	// config register
	logic [PERM_W-1:0] allowed_q;
	logic              cfg_wr;
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_ALLOWED_IDX);
	assign prdata = (paddr[2] == REG_ALLOWED_IDX) ? 32'(allowed_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			allowed_q <= '1;
		end else if (cfg_wr) begin
			allowed_q <= pwdata[PERM_W-1:0];
		end
	end

	// command registers
	cmd_t              cmd_q;
	logic [ST_W-1:0]   st_q;
	logic [LEN_W-1:0]  len_q;
	logic [LEN_W-1:0]  rem_q;
	logic [LEN_W-1:0]  run_q;
	logic [IDX_W-1:0]  rd_addr_q;
	logic [IDX_W-1:0]  proc_addr_q;
	logic              proc_vld_q;
	logic [IDX_W-1:0]  clr_q;

	// result staging and output register
	sts_t              res_sts_q;
	logic [FOUND_W-1:0] res_found_q;
	logic [RD_W-1:0]   res_rd_q;
	logic              m_tvalid_q;
	logic [15:0]       m_tdata_q;

	// RAM
	logic                      ram_we;
	logic [IDX_W-1:0]          ram_waddr;
	logic [BITS_PER_STATE-1:0] ram_wdata;
	logic [BITS_PER_STATE-1:0] ram_rdata;

	mbsra_ram #(
		.DEPTH(CAPACITY),
		.WIDTH(BITS_PER_STATE),
		.AW   (IDX_W)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(rd_addr_q),
		.rdata(ram_rdata)
	);

	// shared compare unit
	unit_req_t ureq;
	unit_res_t ures;

	assign ureq.old_state = ram_rdata;
	assign ureq.target    = st_q;
	assign ureq.run       = run_q;
	assign ureq.rem       = rem_q;
	assign ureq.len       = len_q;
	assign ureq.addr      = proc_addr_q;
	assign ureq.allowed   = allowed_q;

	mbsra_unit u_unit (
		.req(ureq),
		.res(ures)
	);

	// argument checks at accept
	logic             st_ok;
	logic             len_ok;
	logic [SUM_W-1:0] end_sum;
	logic             in_range;
	logic             len_over;
	logic             start_over;
	assign st_ok      = ({1'b0, in_st} < 3'(STATE_LIMIT));
	assign len_ok     = (in_len != '0);
	assign end_sum    = SUM_W'(in_start) + SUM_W'(in_len);
	assign in_range   = (end_sum <= SUM_W'(CAPACITY));
	assign len_over   = (SUM_W'(in_len) > SUM_W'(CAPACITY));
	assign start_over = (SUM_W'(in_start) >= SUM_W'(CAPACITY));

	// per-entry decision while scanning
	logic set_write;
	logic fin;
	sts_t fin_sts;
	logic [FOUND_W-1:0] fin_found;
	logic [RD_W-1:0]    fin_rd;

	always_comb begin
		set_write = 1'b0;
		fin       = 1'b0;
		fin_sts   = STS_OK;
		fin_found = '0;
		fin_rd    = '0;
		if (state_q == ST_SCAN && proc_vld_q) begin
			case (cmd_q)
				CMD_FIND: begin
					if (ures.run_hit) begin
						fin       = 1'b1;
						fin_found = FOUND_W'(ures.found);
					end else if (ures.addr_end) begin
						fin     = 1'b1;
						fin_sts = STS_FAIL;
					end
				end
				CMD_CHECK: begin
					if (!ures.match) begin
						fin     = 1'b1;
						fin_sts = STS_FAIL;
					end else if (ures.rem_last) begin
						fin = 1'b1;
					end
				end
				CMD_READ: begin
					fin    = 1'b1;
					fin_rd = RD_W'(ram_rdata);
				end
				CMD_SET: begin
					if (!ures.permit) begin
						fin     = 1'b1;
						fin_sts = STS_FAIL;
					end else begin
						set_write = 1'b1;
						fin       = ures.rem_last;
					end
				end
				default: begin
					fin     = 1'b1;
					fin_sts = STS_INVALID;
				end
			endcase
		end
	end

	always_comb begin
		if (state_q == ST_CLEAR) begin
			ram_we    = 1'b1;
			ram_waddr = clr_q;
			ram_wdata = '0;
		end else begin
			ram_we    = set_write;
			ram_waddr = proc_addr_q;
			ram_wdata = BITS_PER_STATE'(st_q);
		end
	end

	logic out_free;
	assign out_free = !m_tvalid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_q      <= '0;
			proc_vld_q <= 1'b0;
			m_tvalid_q <= 1'b0;
		end else begin
			// a new result loads over a taken one; otherwise a take clears it
			if (state_q == ST_DONE && out_free) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
			case (state_q)
				ST_CLEAR: begin
					clr_q <= clr_q + IDX_W'(1);
					if (clr_q == IDX_W'(CAPACITY - 1)) begin
						state_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					proc_vld_q <= 1'b0;
					if (s_tvalid) begin
						case (cmd_t'(s_tuser))
							CMD_FIND: begin
								if (!(st_ok && len_ok)) begin
									state_q <= ST_DONE;
								end else if (len_over) begin
									state_q <= ST_DONE;
								end else begin
									state_q <= ST_SCAN;
								end
							end
							CMD_CHECK, CMD_SET: begin
								state_q <= (st_ok && len_ok && in_range) ? ST_SCAN : ST_DONE;
							end
							CMD_READ: begin
								state_q <= start_over ? ST_DONE : ST_SCAN;
							end
							default: state_q <= ST_DONE;
						endcase
					end
				end
				ST_SCAN: begin
					proc_vld_q <= !fin;
					if (fin) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				cmd_q       <= cmd_t'(s_tuser);
				st_q        <= in_st;
				len_q       <= in_len;
				rem_q       <= in_len;
				run_q       <= '0;
				res_found_q <= '0;
				res_rd_q    <= '0;
				rd_addr_q   <= (cmd_t'(s_tuser) == CMD_FIND) ? '0 : IDX_W'(in_start);
				// immediate verdicts; overwritten when a scan runs
				if (cmd_t'(s_tuser) == CMD_FIND && st_ok && len_ok && len_over) begin
					res_sts_q <= STS_FAIL;
				end else begin
					res_sts_q <= STS_INVALID;
				end
			end
			ST_SCAN: begin
				rd_addr_q   <= rd_addr_q + IDX_W'(1);
				proc_addr_q <= rd_addr_q;
				if (proc_vld_q) begin
					rem_q <= rem_q - LEN_W'(1);
					run_q <= ures.run_next;
				end
				if (fin) begin
					res_sts_q   <= fin_sts;
					res_found_q <= fin_found;
					res_rd_q    <= fin_rd;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					m_tdata_q <= {2'b00, res_rd_q, res_found_q, res_sts_q};
				end
			end
			default: ;
		endcase
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;

	// one item at a time
	a_single_item: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("item accepted while previous item in flight");

	// found_index and read_state are zero unless the command succeeded
	a_zero_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && (m_tdata[1:0] != STS_OK)) |-> (m_tdata[13:2] == '0))
		else $error("nonzero result fields on failed command");

	// store is only written by the sweep or by a set
	a_write_src: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && (state_q != ST_CLEAR)) |-> (cmd_q == CMD_SET && state_q == ST_SCAN))
		else $error("store write outside set command");

	// pending entry data exists only during a scan
	a_proc_scan: assert property (@(posedge clk) disable iff (!arst_n)
		proc_vld_q |-> (state_q == ST_SCAN))
		else $error("entry in flight outside scan");

endmodule

// ===== tb/sv/alloc_checker.sv =====
// Scoreboard for the multi-bit state run allocator: keeps its own copy of the
// state store and the permission mask, predicts each result and compares it.
// Depends on mbsra_pkg.
module alloc_checker import mbsra_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_tvalid,
	input  logic              s_tready,
	input  logic [23:0]       s_tdata,
	input  logic [CMD_W-1:0]  s_tuser,
	input  logic              m_tvalid,
	input  logic              m_tready,
	input  logic [15:0]       m_tdata,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [ADDR_W-1:0] paddr,
	input  logic [31:0]       pwdata,
	input  logic              pready,
	output int                fail_count,
	output int                pending
);

	localparam int MAX_SHOWN   = 10;
	localparam int PERM_STRIDE = 4;	// mask bit = old*4 + new

	typedef struct packed {
		sts_t               status;
		logic [FOUND_W-1:0] found;
		logic [RD_W-1:0]    rd;
	} outcome_t;

	logic [BITS_PER_STATE-1:0] shadow [CAPACITY];
	logic [PERM_W-1:0]         permit_mask;
	outcome_t                  outcomes_due [$];
	int                        mismatches;

	// Expected result of one command; applies set writes to the shadow store.
	function automatic outcome_t command_outcome(input cmd_t cmd, input logic [ST_W-1:0] st,
			input logic [LEN_W-1:0] len, input logic [START_W-1:0] at);
		outcome_t o;
		bit       args_ok;
		bit       fits;
		int       i;
		int       streak;
		int       old;
		o.status = STS_INVALID;
		o.found  = '0;
		o.rd     = '0;
		args_ok  = (int'(st) < STATE_LIMIT) && (len != '0);
		fits     = (int'(at) + int'(len)) <= CAPACITY;
		case (cmd)
			CMD_FIND: begin
				if (args_ok) begin
					o.status = STS_FAIL;
					streak   = 0;
					if (int'(len) <= CAPACITY) begin
						// first fit: lowest start whose run ends inside the store
						for (i = 0; i < CAPACITY && o.status != STS_OK; i++) begin
							streak = (shadow[i] == st) ? streak + 1 : 0;
							if (streak == int'(len)) begin
								o.status = STS_OK;
								o.found  = FOUND_W'(i - int'(len) + 1);
							end
						end
					end
				end
			end
			CMD_CHECK: begin
				if (args_ok && fits) begin
					o.status = STS_OK;
					for (i = 0; i < int'(len); i++)
						if (shadow[int'(at) + i] != st)
							o.status = STS_FAIL;
				end
			end
			CMD_READ: begin
				if (int'(at) < CAPACITY) begin
					o.status = STS_OK;
					o.rd     = RD_W'(shadow[at]);
				end
			end
			default: begin
				if (args_ok && fits) begin
					o.status = STS_OK;
					// stop at the first refused entry, earlier writes stay
					for (i = 0; i < int'(len) && o.status == STS_OK; i++) begin
						old = int'(shadow[int'(at) + i]);
						if (!permit_mask[old * PERM_STRIDE + int'(st)])
							o.status = STS_FAIL;
						else
							shadow[int'(at) + i] = st[BITS_PER_STATE-1:0];
					end
				end
			end
		endcase
		return o;
	endfunction

	task automatic flag(input string what, input logic [15:0] want, input logic [15:0] got);
		mismatches++;
		if (mismatches <= MAX_SHOWN)
			$display("%0t mismatch: %s expected %0h got %0h", $realtime, what, want, got);
	endtask

	always @(posedge clk or negedge arst_n) begin
		outcome_t want;
		if (!arst_n) begin
			for (int k = 0; k < CAPACITY; k++)
				shadow[k] = '0;
			permit_mask = '1;
			mismatches  = 0;
		end else begin
			// m_tdata: [1:0] status, [11:2] found_index, [13:12] read_state
			if (m_tvalid && m_tready) begin
				if (outcomes_due.size() == 0) begin
					flag("result with no command waiting", '0, m_tdata);
				end else begin
					want = outcomes_due.pop_front();
					if (m_tdata[1:0] !== want.status)
						flag("status", 16'(want.status), 16'(m_tdata[1:0]));
					if (m_tdata[11:2] !== want.found)
						flag("found_index", 16'(want.found), 16'(m_tdata[11:2]));
					if (m_tdata[13:12] !== want.rd)
						flag("read_state", 16'(want.rd), 16'(m_tdata[13:12]));
				end
			end
			// s_tdata: [1:0] state_value, [12:2] run_length, [22:13] start_index
			if (s_tvalid && s_tready)
				outcomes_due.push_back(command_outcome(cmd_t'(s_tuser), s_tdata[1:0],
					s_tdata[12:2], s_tdata[22:13]));
			if (psel && penable && pwrite && pready && paddr == {REG_ALLOWED_IDX, 2'b00})
				permit_mask = pwdata[PERM_W-1:0];
		end
		fail_count <= mismatches;
		pending    <= outcomes_due.size();
	end

endmodule

// ===== tb/sv/tb_top.sv =====
// Top of the allocator testbench: clock, reset, command stimulus, APB writes
// and the verdict. Depends on mbsra_pkg, alloc_checker and the allocator RTL.
module tb_top;
	import mbsra_pkg::*;

	localparam int LIMIT_CYCLES    = 3_000_000;
	localparam int BLOCKS          = 6;
	localparam int ITEMS_PER_BLOCK = 92;
	localparam logic [PERM_W-1:0] PERM_ALL = '1;

	logic              clk = 1'b0;
	logic              arst_n;
	logic              s_tvalid;
	logic              s_tready;
	logic [23:0]       s_tdata;	// [1:0] state_value, [12:2] run_length, [22:13] start_index
	logic [CMD_W-1:0]  s_tuser;	// [1:0] command
	logic              m_tvalid;
	logic              m_tready = 1'b0;
	logic [15:0]       m_tdata;	// [1:0] status, [11:2] found_index, [13:12] read_state
	logic              psel;
	logic              penable;
	logic              pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [31:0]       pwdata;
	logic [31:0]       prdata;
	logic              pready;

	int fail_count;
	int pending;
	int cycles = 0;
	int src_idle;	// percent of cycles the command side holds back
	int sink_idle;	// percent of cycles the result side stalls

	multi_bit_state_run_allocator u_top (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata (m_tdata),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	alloc_checker u_check (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.pready    (pready),
		.fail_count(fail_count),
		.pending   (pending)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// result side back-pressure, redrawn every cycle
	always @(posedge clk) begin
		m_tready <= ($urandom_range(0, 99) >= sink_idle);
	end

	// watchdog: a lost result or a hung block ends here
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT_CYCLES) begin
			$display("RESULT: ERROR");
			$finish;
		end
	end

	// Offer one command item and return at the edge that accepts it. tvalid
	// is left high so back-to-back items never drop it within one step.
	task automatic push(input cmd_t c, input logic [ST_W-1:0] st,
			input logic [LEN_W-1:0] len, input logic [START_W-1:0] at);
		while ($urandom_range(0, 99) < src_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= c;
		s_tdata  <= {1'b0, at, len, st};
		do @(posedge clk); while (!s_tready);
	endtask

	// APB write of the permission mask: setup cycle, then access cycle
	task automatic reg_write(input logic [PERM_W-1:0] v);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {REG_ALLOWED_IDX, 2'b00};
		pwdata  <= 32'(v);
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
	endtask

	// Drop tvalid and wait until every outstanding result has come back.
	// Every command yields a result, so a short pause is enough afterwards.
	task automatic settle();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (8) @(posedge clk);
	endtask

	// Mostly short runs; a few zero, a few long ones and a few at or past the store size.
	function automatic logic [LEN_W-1:0] pick_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 2)
			return '0;
		if (r < 70)
			return LEN_W'($urandom_range(1, 16));
		if (r < 90)
			return LEN_W'($urandom_range(17, 128));
		if (r < 97)
			return LEN_W'($urandom_range(129, CAPACITY - 1));
		return LEN_W'($urandom_range(CAPACITY, (1 << LEN_W) - 1));
	endfunction

	// Permission mask used by each random block
	function automatic logic [PERM_W-1:0] block_mask(input int blk);
		case (blk)
			0:       return PERM_ALL;
			1:       return 16'h111F;	// alloc/free only: 0 -> any, any -> 0
			2:       return '0;	// every set refused at its first entry
			3:       return PERM_W'($urandom_range(0, (1 << PERM_W) - 1));
			4:       return 16'h7BDE;	// rewriting the same state is refused
			default: return PERM_ALL;
		endcase
	endfunction

	// Random block: allocation-style sequences (set, check it, read inside it,
	// sometimes find the same run and free it again) mixed with noise items.
	task automatic run_block(input int quota);
		int                 done_n;
		logic [LEN_W-1:0]   len;
		logic [ST_W-1:0]    st;
		logic [START_W-1:0] at;
		done_n = 0;
		while (done_n < quota) begin
			if ($urandom_range(0, 99) < 65) begin
				len = pick_len();
				if (len == '0 || int'(len) > CAPACITY)
					len = LEN_W'($urandom_range(1, 8));
				st = ST_W'($urandom_range(0, STATE_LIMIT - 1));
				at = START_W'($urandom_range(0, CAPACITY - int'(len)));
				push(CMD_SET, st, len, at);
				push(CMD_CHECK, st, len, at);
				// read ignores state and length, so those are junk here
				push(CMD_READ, ST_W'($urandom), LEN_W'($urandom),
					at + START_W'($urandom_range(0, int'(len) - 1)));
				done_n += 3;
				if ($urandom_range(0, 1)) begin
					push(CMD_FIND, st, len, START_W'($urandom));
					done_n++;
				end
				if ($urandom_range(0, 1)) begin
					push(CMD_SET, '0, len, at);
					push(CMD_CHECK, '0, len, at);
					done_n += 2;
				end
			end else begin
				push(cmd_t'($urandom_range(0, 3)), ST_W'($urandom),
					($urandom_range(0, 3) == 0) ? LEN_W'($urandom) : pick_len(),
					START_W'($urandom));
				done_n++;
			end
		end
	endtask

	initial begin
		int blk;
		arst_n   <= 1'b0;
		s_tvalid <= 1'b0;
		s_tuser  <= CMD_READ;
		s_tdata  <= '0;
		psel     <= 1'b0;
		penable  <= 1'b0;
		pwrite   <= 1'b0;
		paddr    <= '0;
		pwdata   <= '0;
		src_idle  = 11;
		sink_idle = 69;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		// mask write lands during the post-reset sweep
		reg_write(PERM_ALL);

		// ---- directed part, store is all zero ----
		push(CMD_READ, 2'd3, '1, '0);	// read ignores state and length
		push(CMD_READ, '0, '0, START_W'(CAPACITY - 1));
		push(CMD_FIND, '0, LEN_W'(CAPACITY), '0);	// whole store is one run
		push(CMD_FIND, '0, LEN_W'(CAPACITY + 1), '0);	// longer than the store
		push(CMD_FIND, '0, '1, '0);
		push(CMD_FIND, 2'd1, 11'd1, '0);	// state absent
		push(CMD_FIND, 2'd2, '0, '0);	// zero length
		push(CMD_CHECK, '0, '0, '0);
		push(CMD_SET, 2'd1, '0, '0);
		push(CMD_CHECK, '0, 11'd1, START_W'(CAPACITY - 1));	// last entry, fits
		push(CMD_CHECK, '0, 11'd2, START_W'(CAPACITY - 1));	// runs past the end
		push(CMD_SET, 2'd3, 11'd2, START_W'(CAPACITY - 1));	// past the end, no write
		push(CMD_SET, 2'd3, 11'd4, START_W'(CAPACITY - 4));
		push(CMD_FIND, 2'd3, 11'd4, '0);	// run sits at the very end
		push(CMD_FIND, 2'd3, 11'd5, '0);	// would need to pass the end
		push(CMD_SET, 2'd2, 11'd3, '0);
		push(CMD_CHECK, 2'd2, 11'd3, '0);
		push(CMD_CHECK, 2'd2, 11'd4, '0);
		push(CMD_READ, '0, '0, 10'd2);
		push(CMD_FIND, '0, 11'd5, '0);	// first fit just after the state-2 run
		settle();
		// forbid 3 -> 1, then set a range that hits a state-3 entry halfway
		reg_write(PERM_ALL & ~(PERM_W'(1) << (3 * 4 + 1)));
		push(CMD_SET, 2'd1, 11'd4, START_W'(CAPACITY - 6));
		push(CMD_READ, '0, '0, START_W'(CAPACITY - 5));	// written before the stop
		push(CMD_READ, '0, '0, START_W'(CAPACITY - 4));	// the refused entry
		push(CMD_CHECK, 2'd1, 11'd2, START_W'(CAPACITY - 6));
		push(CMD_SET, '0, LEN_W'(CAPACITY), '0);	// clear the whole store
		settle();

		// ---- random part: two blocks per idling mode ----
		for (blk = 0; blk < BLOCKS; blk++) begin
			case (blk / 2)
				0: begin
					src_idle  = 11;
					sink_idle = 69;
				end
				1: begin
					src_idle  = 69;
					sink_idle = 11;
				end
				default: begin
					src_idle  = 0;
					sink_idle = 0;
				end
			endcase
			reg_write(block_mask(blk));
			run_block(ITEMS_PER_BLOCK);
			settle();
		end

		// room for any stray late result, a full search at most
		repeat (CAPACITY + 16) @(posedge clk);
		if (fail_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== filelist.f =====
hdl/mbsra_pkg.sv
hdl/mbsra_ram.sv
hdl/mbsra_unit.sv
hdl/multi_bit_state_run_allocator.sv
tb/sv/alloc_checker.sv
tb/sv/tb_top.sv
